/* rtl/csi_sequence_event_decoder_top_macros.svh */
// ----------------------------------------------------------------------------
// CSI decoder assertion macros
// Shared concurrent assertion forms used by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef CSI_SEQUENCE_EVENT_DECODER_TOP_MACROS_SVH
`define CSI_SEQUENCE_EVENT_DECODER_TOP_MACROS_SVH

// Same-cycle implication.
`define CSD_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CSD_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/csd_pkg.sv */
// ----------------------------------------------------------------------------
// csd_pkg
// Types, character codes and key table for the CSI sequence decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csd_pkg;

  localparam int DEFAULT_VALUE_BITS = 16;
  localparam int KEPT_PARAMS        = 3;
  localparam int TDATA_OUT_BITS     = 72;

  // Character codes
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_M_UPPER = 8'h4D;
  localparam logic [7:0] CH_M_LOWER = 8'h6D;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_B       = 8'h42;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_H       = 8'h48;
  localparam logic [7:0] CH_F       = 8'h46;

  // Parameter values with special meaning
  localparam int PASTE_NUM      = 200;
  localparam int WHEEL_UP_0     = 64;
  localparam int WHEEL_DOWN_0   = 65;
  localparam int WHEEL_UP_1     = 96;
  localparam int WHEEL_DOWN_1   = 97;
  localparam int TILDE_TBL_SIZE = 25;

  // Key codes
  localparam logic [4:0] KEY_UP    = 5'd0;
  localparam logic [4:0] KEY_DOWN  = 5'd1;
  localparam logic [4:0] KEY_RIGHT = 5'd2;
  localparam logic [4:0] KEY_LEFT  = 5'd3;
  localparam logic [4:0] KEY_HOME  = 5'd4;
  localparam logic [4:0] KEY_END   = 5'd5;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_KEY   = 2'd1,
    EV_MOUSE = 2'd2
  } event_kind_t;

  typedef enum logic [1:0] {
    MT_DOWN  = 2'd0,
    MT_UP    = 2'd1,
    MT_MOVE  = 2'd2,
    MT_WHEEL = 2'd3
  } mouse_type_t;

  // Packed so that handled lands in bit 0 of tdata.
  typedef struct packed {
    logic signed [16:0] mouse_y;
    logic signed [16:0] mouse_x;
    logic [3:0]         mouse_buttons;
    mouse_type_t        mouse_type;
    logic [15:0]        modifiers;
    logic [4:0]         key_code;
    event_kind_t        event_kind;
    logic               paste_begin;
    logic               handled;
  } result_t;

  // Parser flags shared between accumulator and decoder.
  typedef struct packed {
    logic [1:0] param_count;
    logic       digit_seen;
    logic       at_first_byte;
    logic       leading_lt;
  } acc_flags_t;

  // Tilde key table: 0 = no key, otherwise key code + 1.
  function automatic logic [4:0] tilde_key(input logic [4:0] num);
    logic [4:0] k;
    case (num)
      5'd1:    k = 5'd5;
      5'd2:    k = 5'd7;
      5'd3:    k = 5'd8;
      5'd4:    k = 5'd6;
      5'd5:    k = 5'd9;
      5'd6:    k = 5'd10;
      5'd11:   k = 5'd11;
      5'd12:   k = 5'd12;
      5'd13:   k = 5'd13;
      5'd14:   k = 5'd14;
      5'd15:   k = 5'd15;
      5'd17:   k = 5'd16;
      5'd18:   k = 5'd17;
      5'd19:   k = 5'd18;
      5'd20:   k = 5'd19;
      5'd21:   k = 5'd20;
      5'd23:   k = 5'd21;
      5'd24:   k = 5'd22;
      default: k = 5'd0;
    endcase
    return k;
  endfunction

endpackage

/* rtl/csd_param_acc.sv */
// ----------------------------------------------------------------------------
// csd_param_acc
// Decimal parameter accumulator and parser flags; clears on the final byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "csi_sequence_event_decoder_top_macros.svh"

module csd_param_acc #(
  parameter int VALUE_BITS = csd_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  upd,
  input  logic [7:0]            seq_byte,
  input  logic                  is_final,
  output logic [VALUE_BITS-1:0] p0,
  output logic [VALUE_BITS-1:0] p1,
  output logic [VALUE_BITS-1:0] p2,
  output csd_pkg::acc_flags_t   flags
);

  localparam int PW = VALUE_BITS + 4;

  logic [VALUE_BITS-1:0] pv [csd_pkg::KEPT_PARAMS];
  logic                  is_digit;
  logic                  is_semi;
  logic [3:0]            digit;

  assign is_digit = (seq_byte >= csd_pkg::CH_0) && (seq_byte <= csd_pkg::CH_9);
  assign is_semi  = (seq_byte == csd_pkg::CH_SEMI);
  assign digit    = 4'(seq_byte - csd_pkg::CH_0);

  // value * 10 + digit, saturating at all ones
  function automatic logic [VALUE_BITS-1:0] acc_step(input logic [VALUE_BITS-1:0] v,
                                                     input logic [3:0] d);
    logic [PW-1:0] s;
    s = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + PW'(d);
    return (s[PW-1:VALUE_BITS] != '0) ? '1 : s[VALUE_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < csd_pkg::KEPT_PARAMS; i++) pv[i] <= '0;
      flags.param_count   <= 2'd0;
      flags.digit_seen    <= 1'b0;
      flags.at_first_byte <= 1'b1;
      flags.leading_lt    <= 1'b0;
    end else if (upd) begin
      if (is_final) begin
        for (int i = 0; i < csd_pkg::KEPT_PARAMS; i++) pv[i] <= '0;
        flags.param_count   <= 2'd0;
        flags.digit_seen    <= 1'b0;
        flags.at_first_byte <= 1'b1;
        flags.leading_lt    <= 1'b0;
      end else begin
        if (flags.at_first_byte && seq_byte == csd_pkg::CH_LT) flags.leading_lt <= 1'b1;
        flags.at_first_byte <= 1'b0;
        if (is_digit) begin
          for (int i = 0; i < csd_pkg::KEPT_PARAMS; i++) begin
            if (flags.param_count == 2'(i)) pv[i] <= acc_step(pv[i], digit);
          end
          flags.digit_seen <= 1'b1;
        end else if (is_semi) begin
          if (flags.param_count != 2'd3) flags.param_count <= flags.param_count + 2'd1;
          flags.digit_seen <= 1'b0;
        end
      end
    end
  end

  assign p0 = pv[0];
  assign p1 = pv[1];
  assign p2 = pv[2];

  `CSD_ASSERT_NEXT(a_clear_after_final, clk, rst, upd && is_final, (flags.param_count == 2'd0) && flags.at_first_byte && !flags.digit_seen && !flags.leading_lt && (pv[0] == '0), "parser state not cleared after final item")
  `CSD_ASSERT_NEXT(a_lt_only_first, clk, rst, upd && !is_final && !flags.at_first_byte && !flags.leading_lt, !flags.leading_lt, "leading marker set after first byte")

endmodule

/* rtl/csd_decode.sv */
// ----------------------------------------------------------------------------
// csd_decode
// Maps final byte plus accumulated parameters to one key/mouse/paste result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csd_decode #(
  parameter int VALUE_BITS = csd_pkg::DEFAULT_VALUE_BITS
) (
  input  logic [7:0]            final_byte,
  input  logic [VALUE_BITS-1:0] p0,
  input  logic [VALUE_BITS-1:0] p1,
  input  logic [VALUE_BITS-1:0] p2,
  input  csd_pkg::acc_flags_t   flags,
  output csd_pkg::result_t      res
);

  // working width: covers the value and the 17-bit coordinate fields
  localparam int W = (VALUE_BITS > 17) ? VALUE_BITS : 17;

  logic [W-1:0] p0w, p1w, p2w;
  logic         n_ge1, n_ge2, n_ge3;
  logic         is_wheel;
  logic [4:0]   tk;
  logic [15:0]  key_mods;

  assign p0w = W'(p0);
  assign p1w = W'(p1);
  assign p2w = W'(p2);

  // parameter count = completed params + one open param if digits seen
  assign n_ge1 = (flags.param_count != 2'd0) || flags.digit_seen;
  assign n_ge2 = (flags.param_count[1]) || (flags.param_count == 2'd1 && flags.digit_seen);
  assign n_ge3 = (flags.param_count == 2'd3) || (flags.param_count == 2'd2 && flags.digit_seen);

  assign is_wheel = (p0w == W'(csd_pkg::WHEEL_UP_0)) || (p0w == W'(csd_pkg::WHEEL_DOWN_0)) ||
                    (p0w == W'(csd_pkg::WHEEL_UP_1)) || (p0w == W'(csd_pkg::WHEEL_DOWN_1));
  assign tk       = csd_pkg::tilde_key(p0[4:0]);
  assign key_mods = (!n_ge2 || p1w < W'(2)) ? 16'd0 : 16'(p1w - W'(1));

  always_comb begin
    res = '0;
    if ((final_byte == csd_pkg::CH_M_UPPER || final_byte == csd_pkg::CH_M_LOWER) &&
        flags.leading_lt) begin
      res.handled = 1'b1;
      if (n_ge3) begin
        res.event_kind = csd_pkg::EV_MOUSE;
        res.modifiers  = {13'd0, p0[4], p0[3], p0[2]};
        if (is_wheel) begin
          res.mouse_type    = csd_pkg::MT_WHEEL;
          res.mouse_buttons = p0[0] ? 4'd2 : 4'd1;
        end else begin
          if (final_byte == csd_pkg::CH_M_LOWER) res.mouse_type = csd_pkg::MT_UP;
          else if (p0[5])                        res.mouse_type = csd_pkg::MT_MOVE;
          else                                   res.mouse_type = csd_pkg::MT_DOWN;
          res.mouse_buttons = 4'd1 << p0[1:0];
        end
        res.mouse_x = 17'(p1w - W'(1));
        res.mouse_y = 17'(p2w - W'(1));
      end
    end else if (final_byte == csd_pkg::CH_TILDE) begin
      if (n_ge1) begin
        if (p0w == W'(csd_pkg::PASTE_NUM)) begin
          res.handled     = 1'b1;
          res.paste_begin = 1'b1;
        end else if (p0w < W'(csd_pkg::TILDE_TBL_SIZE) && tk != 5'd0) begin
          res.handled    = 1'b1;
          res.event_kind = csd_pkg::EV_KEY;
          res.key_code   = tk - 5'd1;
          res.modifiers  = key_mods;
        end
      end
    end else begin
      unique case (final_byte)
        csd_pkg::CH_A: res.key_code = csd_pkg::KEY_UP;
        csd_pkg::CH_B: res.key_code = csd_pkg::KEY_DOWN;
        csd_pkg::CH_C: res.key_code = csd_pkg::KEY_RIGHT;
        csd_pkg::CH_D: res.key_code = csd_pkg::KEY_LEFT;
        csd_pkg::CH_H: res.key_code = csd_pkg::KEY_HOME;
        csd_pkg::CH_F: res.key_code = csd_pkg::KEY_END;
        default:       res.key_code = 5'd0;
      endcase
      if (final_byte == csd_pkg::CH_A || final_byte == csd_pkg::CH_B ||
          final_byte == csd_pkg::CH_C || final_byte == csd_pkg::CH_D ||
          final_byte == csd_pkg::CH_H || final_byte == csd_pkg::CH_F) begin
        res.handled    = 1'b1;
        res.event_kind = csd_pkg::EV_KEY;
        res.modifiers  = key_mods;
      end
    end
  end

endmodule

/* rtl/csi_sequence_event_decoder_top.sv */
// ----------------------------------------------------------------------------
// csi_sequence_event_decoder_top
// CSI parameter/final byte decoder giving key, SGR mouse and paste events.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] seq_byte, tlast is_final
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata[64:0] result fields
//
//  One item per cycle sustained while the result side keeps up. A byte is
//  registered on accept and folded into the parameter accumulator as it
//  leaves the input register; a final byte also loads the result register
//  as it leaves, and it leaves only once the result slot is free or draining.
//  Reset (rst, synchronous) empties both registers and returns the parser to
//  its start state. A stalled result only holds back a following final item;
//  parameter bytes keep flowing past it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "csi_sequence_event_decoder_top_macros.svh"

module csi_sequence_event_decoder_top #(
  parameter int VALUE_BITS = csd_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [7:0] seq_byte
  input  logic                               s_axis_tlast,  // is_final
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] handled, [1] paste_begin, [3:2] event_kind, [8:4] key_code,
  // [24:9] modifiers, [26:25] mouse_type, [30:27] mouse_buttons,
  // [47:31] mouse_x, [64:48] mouse_y, [71:65] zero
  output logic [csd_pkg::TDATA_OUT_BITS-1:0] m_axis_tdata
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       in_adv;

  // accumulator outputs
  logic [VALUE_BITS-1:0] p0, p1, p2;
  csd_pkg::acc_flags_t   flags;

  // decode result and output register
  csd_pkg::result_t res;
  csd_pkg::result_t out_res;

  // A final item needs the result slot free (or being drained this cycle).
  assign in_adv        = in_valid && (!in_last || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  csd_param_acc #(
    .VALUE_BITS (VALUE_BITS)
  ) u_acc (
    .clk      (clk),
    .rst      (rst),
    .upd      (in_adv),
    .seq_byte (in_byte),
    .is_final (in_last),
    .p0       (p0),
    .p1       (p1),
    .p2       (p2),
    .flags    (flags)
  );

  csd_decode #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dec (
    .final_byte (in_byte),
    .p0         (p0),
    .p1         (p1),
    .p2         (p2),
    .flags      (flags),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_adv && in_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_last) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {(csd_pkg::TDATA_OUT_BITS - $bits(csd_pkg::result_t))'(0), out_res};

  `CSD_ASSERT_NEXT(a_result_from_final, clk, rst, !(in_adv && in_last) && m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(out_res), "result changed without a final item")
  `CSD_ASSERT_IMPL(a_kind_needs_handled, clk, rst, m_axis_tvalid && (out_res.event_kind != csd_pkg::EV_NONE || out_res.paste_begin), out_res.handled, "event reported on unhandled sequence")
  `CSD_ASSERT_IMPL(a_no_overrun, clk, rst, in_adv && in_last, !m_axis_tvalid || m_axis_tready, "result register overwritten while full")

endmodule

/* test/csi_sequence_event_decoder_top_tb.sv */
// ----------------------------------------------------------------------------
// csi_sequence_event_decoder_top_tb
// Self-checking bench for the CSI key / SGR mouse / paste decoder. Byte
// sequences go in on the slave stream. A bit-exact predictor runs on every
// accepted byte, and each result on the master stream is compared field by
// field with the oldest predicted one. A short directed table comes first,
// then random well-formed sequences mixed with noise. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csi_sequence_event_decoder_top_tb;

  // Tilde key codes beyond the ones the package names
  localparam logic [4:0] KEY_INSERT = 5'd6;
  localparam logic [4:0] KEY_DELETE = 5'd7;
  localparam logic [4:0] KEY_PGUP   = 5'd8;
  localparam logic [4:0] KEY_PGDN   = 5'd9;
  localparam logic [4:0] KEY_F1     = 5'd10;

  localparam logic [15:0] VAL_MAX    = 16'hFFFF;  // parameter saturation (16-bit build)
  localparam int          ITEM_GOAL  = 1550;
  localparam int          DRAIN_WAIT = 20;        // extra wait after the queue empties, for stray results

  // Directed expectation typed in by hand; on = 0 means use the predictor.
  // Mouse fields of a typed row are always zero.
  typedef struct packed {
    logic                 on;
    logic                 handled;
    logic                 paste_begin;
    csd_pkg::event_kind_t kind;
    logic [4:0]           key;
    logic [15:0]          mods;
  } pinned_t;

  // Directed table: each string is the parameter bytes, its last char the final.
  localparam int DIR_ROWS = 9;
  string dir_seq [DIR_ROWS] = '{
    "A",          // plain key right after reset
    "1;99999B",   // modifier saturates, largest modifier value
    "200~",       // bracketed paste start
    "~",          // tilde with no parameter
    "99~",        // unknown tilde number
    "<0;1M",      // mouse report short of three parameters
    "<65;;9M",    // wheel down, empty x parameter gives -1
    ";\377;;;H",  // ignored byte, more than three parameters, all empty
    "\377"        // unknown final at the top byte value
  };
  pinned_t dir_pin [DIR_ROWS] = '{
    '{1'b1, 1'b1, 1'b0, csd_pkg::EV_KEY,  csd_pkg::KEY_UP,   16'd0},
    '{1'b1, 1'b1, 1'b0, csd_pkg::EV_KEY,  csd_pkg::KEY_DOWN, 16'd65534},
    '{1'b1, 1'b1, 1'b1, csd_pkg::EV_NONE, 5'd0,              16'd0},
    '{1'b1, 1'b0, 1'b0, csd_pkg::EV_NONE, 5'd0,              16'd0},
    '{1'b1, 1'b0, 1'b0, csd_pkg::EV_NONE, 5'd0,              16'd0},
    '{1'b1, 1'b1, 1'b0, csd_pkg::EV_NONE, 5'd0,              16'd0},
    '{1'b0, 1'b0, 1'b0, csd_pkg::EV_NONE, 5'd0,              16'd0},
    '{1'b1, 1'b1, 1'b0, csd_pkg::EV_KEY,  csd_pkg::KEY_HOME, 16'd0},
    '{1'b1, 1'b0, 1'b0, csd_pkg::EV_NONE, 5'd0,              16'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  csi_sequence_event_decoder_top uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: parameter accumulators and parser flags
  logic [15:0] param_acc [3];
  logic [1:0]  param_done = 2'd0;   // parameters closed by ';', sticks at 3
  logic        digit_open = 1'b0;
  logic        at_start   = 1'b1;
  logic        mouse_lead = 1'b0;

  csd_pkg::result_t pending_results [$]; // predicted results, oldest first
  pinned_t     feed_pins [$];       // one per driven byte, in send order
  logic [7:0]  seq_buf [$];         // parameter bytes of the sequence being built

  logic        calm = 1'b0;         // no idling on either side while set
  int          mismatches = 0;
  int          bytes_accepted = 0;
  int          n_key = 0, n_mouse = 0, n_paste = 0, n_unhandled = 0, n_other = 0;

  initial begin
    for (int i = 0; i < 3; i++) param_acc[i] = 16'd0;
  end

  function automatic logic [15:0] key_mods(input int unsigned n, input logic [15:0] p);
    return (n >= 2 && p >= 16'd2) ? p - 16'd1 : 16'd0;
  endfunction

  // Fold one byte into the predictor; a final byte yields one result.
  task automatic decode_step(input logic [7:0] b, input logic fin,
                             output logic got, output csd_pkg::result_t r);
    int unsigned grown;
    int unsigned n;
    logic [15:0] p0, p1, p2;
    logic [4:0]  kc;
    logic        hit;
    got = 1'b0;
    r   = '0;
    if (!fin) begin
      if (at_start && b == csd_pkg::CH_LT) mouse_lead = 1'b1;
      at_start = 1'b0;
      if (b >= csd_pkg::CH_0 && b <= csd_pkg::CH_9) begin
        if (param_done < 2'd3) begin
          grown = 32'(param_acc[param_done]) * 10 + 32'(b - csd_pkg::CH_0);
          param_acc[param_done] = (grown > 32'(VAL_MAX)) ? VAL_MAX : grown[15:0];
        end
        digit_open = 1'b1;
      end else if (b == csd_pkg::CH_SEMI) begin
        if (param_done < 2'd3) param_done = param_done + 2'd1;
        digit_open = 1'b0;
      end
    end else begin
      got = 1'b1;
      n = param_done + (digit_open ? 1 : 0);
      if (n > 3) n = 3;
      p0 = param_acc[0];
      p1 = param_acc[1];
      p2 = param_acc[2];
      if ((b == csd_pkg::CH_M_UPPER || b == csd_pkg::CH_M_LOWER) && mouse_lead) begin
        r.handled = 1'b1;
        if (n >= 3) begin
          r.event_kind = csd_pkg::EV_MOUSE;
          r.modifiers  = {13'd0, p0[4], p0[3], p0[2]};  // ctrl, alt, shift
          if (p0 == csd_pkg::WHEEL_UP_0 || p0 == csd_pkg::WHEEL_DOWN_0 ||
              p0 == csd_pkg::WHEEL_UP_1 || p0 == csd_pkg::WHEEL_DOWN_1) begin
            r.mouse_type    = csd_pkg::MT_WHEEL;
            r.mouse_buttons = p0[0] ? 4'd2 : 4'd1;
          end else begin
            r.mouse_type    = (b == csd_pkg::CH_M_LOWER) ? csd_pkg::MT_UP :
                              (p0[5] ? csd_pkg::MT_MOVE : csd_pkg::MT_DOWN);
            r.mouse_buttons = 4'd1 << p0[1:0];
          end
          r.mouse_x = {1'b0, p1} - 17'd1;
          r.mouse_y = {1'b0, p2} - 17'd1;
        end
      end else if (b == csd_pkg::CH_TILDE) begin
        if (n >= 1) begin
          if (p0 == csd_pkg::PASTE_NUM) begin
            r.handled     = 1'b1;
            r.paste_begin = 1'b1;
          end else begin
            hit = 1'b1;
            kc  = 5'd0;
            if (p0 >= 16'd11 && p0 <= 16'd15)      kc = KEY_F1 + 5'(p0 - 16'd11);
            else if (p0 >= 16'd17 && p0 <= 16'd21) kc = KEY_F1 + 5'd5 + 5'(p0 - 16'd17);
            else if (p0 == 16'd23 || p0 == 16'd24) kc = KEY_F1 + 5'd10 + 5'(p0 - 16'd23);
            else begin
              case (p0)
                16'd1:   kc = csd_pkg::KEY_HOME;
                16'd2:   kc = KEY_INSERT;
                16'd3:   kc = KEY_DELETE;
                16'd4:   kc = csd_pkg::KEY_END;
                16'd5:   kc = KEY_PGUP;
                16'd6:   kc = KEY_PGDN;
                default: hit = 1'b0;
              endcase
            end
            if (hit) begin
              r.handled    = 1'b1;
              r.event_kind = csd_pkg::EV_KEY;
              r.key_code   = kc;
              r.modifiers  = key_mods(n, p1);
            end
          end
        end
      end else begin
        hit = 1'b1;
        kc  = 5'd0;
        case (b)
          csd_pkg::CH_A: kc = csd_pkg::KEY_UP;
          csd_pkg::CH_B: kc = csd_pkg::KEY_DOWN;
          csd_pkg::CH_C: kc = csd_pkg::KEY_RIGHT;
          csd_pkg::CH_D: kc = csd_pkg::KEY_LEFT;
          csd_pkg::CH_H: kc = csd_pkg::KEY_HOME;
          csd_pkg::CH_F: kc = csd_pkg::KEY_END;
          default:       hit = 1'b0;
        endcase
        if (hit) begin
          r.handled    = 1'b1;
          r.event_kind = csd_pkg::EV_KEY;
          r.key_code   = kc;
          r.modifiers  = key_mods(n, p1);
        end
      end
      // a final byte always returns the parser to its start state
      for (int i = 0; i < 3; i++) param_acc[i] = 16'd0;
      param_done = 2'd0;
      digit_open = 1'b0;
      at_start   = 1'b1;
      mouse_lead = 1'b0;
    end
  endtask

  task automatic field_check(input string name, input longint e, input longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      mismatches++;
    end
  endtask

  // Monitor and scoreboard. Everything is sampled at the rising edge, where
  // the values are those from before the edge on both sides.
  always @(posedge clk) begin
    csd_pkg::result_t act, exp;
    csd_pkg::result_t pred;
    pinned_t pin;
    logic    got;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        act = m_axis_tdata[64:0];
        if (pending_results.size() == 0) begin
          $error("result item with no expectation waiting");
          mismatches++;
        end else begin
          exp = pending_results.pop_front();
          field_check("handled",       exp.handled,       act.handled);
          field_check("paste_begin",   exp.paste_begin,   act.paste_begin);
          field_check("event_kind",    exp.event_kind,    act.event_kind);
          field_check("key_code",      exp.key_code,      act.key_code);
          field_check("modifiers",     exp.modifiers,     act.modifiers);
          field_check("mouse_type",    exp.mouse_type,    act.mouse_type);
          field_check("mouse_buttons", exp.mouse_buttons, act.mouse_buttons);
          field_check("mouse_x",       exp.mouse_x,       act.mouse_x);
          field_check("mouse_y",       exp.mouse_y,       act.mouse_y);
          if (!exp.handled)                             n_unhandled++;
          else if (exp.paste_begin)                     n_paste++;
          else if (exp.event_kind == csd_pkg::EV_KEY)   n_key++;
          else if (exp.event_kind == csd_pkg::EV_MOUSE) n_mouse++;
          else                                          n_other++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_accepted++;
        pin = feed_pins.pop_front();
        decode_step(s_axis_tdata, s_axis_tlast, got, pred);
        if (got) begin
          // hand-typed rows override the predictor (which still tracks state)
          if (pin.on) begin
            pred             = '0;
            pred.handled     = pin.handled;
            pred.paste_begin = pin.paste_begin;
            pred.event_kind  = pin.kind;
            pred.key_code    = pin.key;
            pred.modifiers   = pin.mods;
          end
          pending_results.insert(pending_results.size(), pred);
        end
      end
    end
  end

  // Result side backpressure: ~19% stall, none while calm
  always @(posedge clk) begin
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 19);
  end

  // One byte on the slave stream; returns in the step of its handshake edge.
  task automatic send_item(input logic [7:0] b, input logic fin, input pinned_t pin);
    while (!calm && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    feed_pins.insert(feed_pins.size(), pin);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_seq(input logic [7:0] fin, input pinned_t pin);
    for (int i = 0; i < seq_buf.size(); i++) send_item(seq_buf[i], 1'b0, '0);
    send_item(fin, 1'b1, pin);
    seq_buf.delete();
  endtask

  function automatic int unsigned coord_val();
    case ($urandom_range(19))
      0:       return 0;
      1:       return $urandom_range(9999999, 65536);  // saturates
      2:       return 65535;
      default: return $urandom_range(300, 1);
    endcase
  endfunction

  function automatic int unsigned mod_val();
    case ($urandom_range(9))
      0:       return 0;
      1:       return $urandom_range(99999, 65536);
      default: return $urandom_range(16, 1);
    endcase
  endfunction

  // Mostly well-formed sequences with random content, the rest noise.
  task automatic random_sequence();
    int unsigned pick;
    int unsigned junk;
    int unsigned btn;
    logic [7:0]  fin;
    string       txt;
    pick = $urandom_range(99);
    txt  = "";
    if (pick < 32) begin
      // SGR mouse report
      case ($urandom_range(7))
        0, 1:    btn = ($urandom_range(1) ? csd_pkg::WHEEL_UP_0 : csd_pkg::WHEEL_UP_1) +
                       $urandom_range(1);
        2:       btn = $urandom_range(65535);
        default: btn = $urandom_range(127);
      endcase
      txt = ($urandom_range(19) == 0) ? "" : "<";
      if ($urandom_range(14) == 0) txt = {" ", txt};  // '<' no longer leads
      txt = {txt, $sformatf("%0d;%0d", btn, coord_val())};
      case ($urandom_range(9))
        0:       ;  // two parameters only
        1:       txt = {txt, $sformatf(";%0d;%0d", coord_val(), coord_val())};
        default: txt = {txt, $sformatf(";%0d", coord_val())};
      endcase
      fin = $urandom_range(1) ? csd_pkg::CH_M_UPPER : csd_pkg::CH_M_LOWER;
      if ($urandom_range(19) == 0) fin = 8'($urandom_range(255));
    end else if (pick < 56) begin
      // numbered key or paste start
      case ($urandom_range(9))
        0:       txt = "";
        1, 2:    txt = $sformatf("%0d", csd_pkg::PASTE_NUM);
        3:       txt = $sformatf("%0d", $urandom_range(70000));
        default: txt = $sformatf("%0d", $urandom_range(26));
      endcase
      if ($urandom_range(1)) txt = {txt, $sformatf(";%0d", mod_val())};
      fin = csd_pkg::CH_TILDE;
    end else if (pick < 80) begin
      // cursor, Home, End
      case ($urandom_range(3))
        0:       txt = $sformatf("1;%0d", mod_val());
        1:       txt = $sformatf("%0d", $urandom_range(9));
        2:       txt = $sformatf(";%0d", mod_val());
        default: txt = "";
      endcase
      case ($urandom_range(5))
        0:       fin = csd_pkg::CH_A;
        1:       fin = csd_pkg::CH_B;
        2:       fin = csd_pkg::CH_C;
        3:       fin = csd_pkg::CH_D;
        4:       fin = csd_pkg::CH_H;
        default: fin = csd_pkg::CH_F;
      endcase
    end else begin
      // noise: arbitrary bytes and an arbitrary final
      junk = $urandom_range(8);
      repeat (junk) seq_buf.insert(seq_buf.size(), 8'($urandom_range(255)));
      fin = 8'($urandom_range(255));
    end
    for (int i = 0; i < txt.len(); i++) seq_buf.insert(seq_buf.size(), txt[i]);
    send_seq(fin, '0);
  endtask

  initial begin
    string txt;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      txt = dir_seq[i];
      for (int j = 0; j < txt.len() - 1; j++) seq_buf.insert(seq_buf.size(), txt[j]);
      send_seq(txt[txt.len() - 1], dir_pin[i]);
    end

    // random part, with one stretch of full throughput in the middle
    while (bytes_accepted < ITEM_GOAL) begin
      calm = (bytes_accepted > 600 && bytes_accepted < 900);
      random_sequence();
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    // drain, then allow for anything still in flight
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end

    $display("Fed %0d bytes; checked %0d key, %0d mouse, %0d paste start results,",
             bytes_accepted, n_key, n_mouse, n_paste);
    $display("plus %0d handled-without-event and %0d unhandled sequences.",
             n_other, n_unhandled);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* csi_sequence_event_decoder_top.f */
+incdir+rtl
rtl/csd_pkg.sv
rtl/csd_param_acc.sv
rtl/csd_decode.sv
rtl/csi_sequence_event_decoder_top.sv
test/csi_sequence_event_decoder_top_tb.sv
